@@ design/xoshiro256ss_generator_macros.svh @@
// assertion macros for the xoshiro256** generator checker
// expects clk and rst in scope where the macros are used
`ifndef XOSHIRO256SS_GENERATOR_MACROS_SVH
`define XOSHIRO256SS_GENERATOR_MACROS_SVH

// same-cycle implication, ignored while in reset
`define XSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("xss check failed");

// next-cycle implication, ignored while in reset
`define XSS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("xss check failed");

// next-cycle implication that also holds through reset
`define XSS_ASSERT_NXT_RAW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("xss check failed");

`endif

@@ design/xss_pkg.sv @@
// shared types and constants for the xoshiro256** generator
// no dependencies
package xss_pkg;

  localparam int WORD_W  = 64;
  localparam int RANGE_W = 32;
  localparam int SPAN_W  = RANGE_W + 1;

  localparam logic [WORD_W-1:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
  localparam logic [WORD_W-1:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
  localparam logic [WORD_W-1:0] MIX_MUL_B  = 64'h94d049bb133111eb;

  localparam int MIX_SH_A  = 30;
  localparam int MIX_SH_B  = 27;
  localparam int MIX_SH_C  = 31;
  localparam int XS_SHIFT  = 17;
  localparam int XS_ROT    = 45;
  localparam int SCR_ROT   = 7;

  typedef enum logic [1:0] {
    OP_RAW    = 2'd0,
    OP_RANGE  = 2'd1,
    OP_RESEED = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int k);
    return (x << k) | (x >> (WORD_W - k));
  endfunction

endpackage

@@ design/xss_ifs.sv @@
// request, response and seed write channels of the generator
// depends on xss_pkg
interface xss_req_if;
  import xss_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                opcode;
  logic signed [RANGE_W-1:0] range_low;
  logic signed [RANGE_W-1:0] range_high;
  modport source (output valid, opcode, range_low, range_high, input ready);
  modport sink (input valid, opcode, range_low, range_high, output ready);
endinterface

interface xss_rsp_if;
  import xss_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [WORD_W-1:0]         raw_word;
  logic signed [RANGE_W-1:0] ranged_value;
  logic [WORD_W-1:0]         generated_count;
  modport source (output valid, raw_word, ranged_value, generated_count, input ready);
  modport sink (input valid, raw_word, ranged_value, generated_count, output ready);
endinterface

interface xss_cfg_if;
  import xss_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] seed_value;
  modport source (output valid, seed_value, input ready);
  modport sink (input valid, seed_value, output ready);
endinterface

@@ design/xss_mul.sv @@
// bit-serial 64 by 64 multiplier, product modulo 2^64, one bit a cycle
// depends on xss_pkg
module xss_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [xss_pkg::WORD_W-1:0] a,
  input  logic [xss_pkg::WORD_W-1:0] b,
  output logic                      done,
  output logic [xss_pkg::WORD_W-1:0] product
);
  import xss_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] mcand;
  logic [WORD_W-1:0] mplier;
  logic [WORD_W-1:0] acc;

  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(WORD_W - 1));
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        mcand  <= a;
        mplier <= b;
        acc    <= '0;
      end else if (busy) begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 1'b1;
        if (cnt == CNT_W'(WORD_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

@@ design/xss_mod.sv @@
// bit-serial restoring remainder of a 64-bit word by a 33-bit span
// depends on xss_pkg
module xss_mod (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [xss_pkg::WORD_W-1:0]  dividend,
  input  logic [xss_pkg::SPAN_W-1:0]  divisor,
  output logic                       done,
  output logic [xss_pkg::RANGE_W-1:0] remainder
);
  import xss_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] dvd;
  logic [SPAN_W-1:0] dvs;
  logic [SPAN_W-1:0] rem;
  logic [SPAN_W:0]   trial;
  logic [SPAN_W:0]   diff;

  // remainder stays below the span, which is at most 2^32
  assign remainder = rem[RANGE_W-1:0];

  always_comb begin
    trial = {rem, dvd[WORD_W-1]};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(WORD_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= diff[SPAN_W-1:0];
        end else begin
          rem <= trial[SPAN_W-1:0];
        end
        dvd <= dvd << 1;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(WORD_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

@@ design/xoshiro256ss_generator.sv @@
// xoshiro256** generator with splitmix64 reseeding, one item at a time
// raw word: accept, S_SCRAM, S_FINISH, then S_DONE loads the output register once it is free;
//   ranged value also waits in S_MOD on the bit-serial remainder unit; no new request until S_IDLE
// reseed: four splitmix draws through the bit-serial multiplier
// after reset the block runs a seed-zero expansion (req.ready low);
//   the seed write channel is always ready
module xoshiro256ss_generator (
  input logic clk,
  input logic rst,
  xss_cfg_if.sink   cfg,
  xss_req_if.sink   req,
  xss_rsp_if.source rsp
);
  import xss_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCRAM  = 8'b0000_0010,
    S_FINISH = 8'b0000_0100,
    S_MOD    = 8'b0000_1000,
    S_DRAW   = 8'b0001_0000,
    S_MUL_A  = 8'b0010_0000,
    S_MUL_B  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state;

  logic [WORD_W-1:0] seed_value;
  logic [WORD_W-1:0] split_counter;
  logic [WORD_W-1:0] step_count;
  logic [WORD_W-1:0] words [4];
  logic [1:0]        draw_idx;
  logic              init_q;

  op_t                       op_q;
  logic signed [RANGE_W-1:0] lo_q;
  logic [SPAN_W-1:0]         span_q;
  logic [WORD_W-1:0]         p_q;
  logic [WORD_W-1:0]         raw_q;
  logic [RANGE_W-1:0]        ranged_q;

  logic                      rsp_valid;
  logic [WORD_W-1:0]         rsp_raw;
  logic [RANGE_W-1:0]        rsp_ranged;
  logic [WORD_W-1:0]         rsp_count;

  logic [SPAN_W-1:0]  span;
  logic               empty_range;
  logic [WORD_W-1:0]  ctr_next;
  logic [WORD_W-1:0]  scr_rot;
  logic [WORD_W-1:0]  word;
  logic [WORD_W-1:0]  n0, n1, n2, n3;

  logic              mul_start;
  logic [WORD_W-1:0] mul_a;
  logic [WORD_W-1:0] mul_b;
  logic              mul_done;
  logic [WORD_W-1:0] mul_prod;

  logic               mod_start;
  logic               mod_done;
  logic [RANGE_W-1:0] mod_rem;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);

  assign rsp.valid           = rsp_valid;
  assign rsp.raw_word        = rsp_raw;
  assign rsp.ranged_value    = rsp_ranged;
  assign rsp.generated_count = rsp_count;

  always_comb begin
    span = {req.range_high[RANGE_W-1], req.range_high}
         - {req.range_low[RANGE_W-1], req.range_low} + SPAN_W'(1);
    empty_range = (req.range_low >= req.range_high);
    ctr_next    = split_counter + GOLDEN_INC;

    // scrambler: rotl(w1 * 5, 7) * 9, the first product registered in p_q
    scr_rot = rotl(p_q, SCR_ROT);
    word    = scr_rot + (scr_rot << 3);

    n2 = words[2] ^ words[0];
    n3 = words[3] ^ words[1];
    n1 = words[1] ^ n2;
    n0 = words[0] ^ n3;

    mul_start = (state == S_DRAW) || ((state == S_MUL_A) && mul_done);
    if (state == S_DRAW) begin
      mul_a = ctr_next ^ (ctr_next >> MIX_SH_A);
      mul_b = MIX_MUL_A;
    end else begin
      mul_a = mul_prod ^ (mul_prod >> MIX_SH_B);
      mul_b = MIX_MUL_B;
    end

    mod_start = (state == S_FINISH) && (op_q == OP_RANGE);
  end

  xss_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  xss_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (word),
    .divisor   (span_q),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_DRAW;
      seed_value    <= '0;
      split_counter <= '0;
      step_count    <= '0;
      draw_idx      <= '0;
      init_q        <= 1'b1;
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        seed_value <= cfg.seed_value;
      end
      // in S_DONE the output register is reloaded below instead
      if (rsp_valid && rsp.ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_q     <= op_t'(req.opcode);
            lo_q     <= req.range_low;
            span_q   <= span;
            raw_q    <= '0;
            ranged_q <= '0;
            case (op_t'(req.opcode))
              OP_RAW: begin
                state <= S_SCRAM;
              end
              OP_RANGE: begin
                if (empty_range) begin
                  ranged_q <= req.range_low;
                  state    <= S_DONE;
                end else begin
                  state <= S_SCRAM;
                end
              end
              OP_RESEED: begin
                split_counter <= seed_value;
                draw_idx      <= '0;
                state         <= S_DRAW;
              end
              OP_CLEAR: begin
                step_count <= '0;
                state      <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end

        S_SCRAM: begin
          p_q   <= words[1] + (words[1] << 2);
          state <= S_FINISH;
        end

        S_FINISH: begin
          raw_q      <= word;
          words[0]   <= n0;
          words[1]   <= n1;
          words[2]   <= n2 ^ (words[1] << XS_SHIFT);
          words[3]   <= rotl(n3, XS_ROT);
          step_count <= step_count + 1'b1;
          state      <= (op_q == OP_RANGE) ? S_MOD : S_DONE;
        end

        S_MOD: begin
          if (mod_done) begin
            ranged_q <= lo_q + mod_rem;
            state    <= S_DONE;
          end
        end

        S_DRAW: begin
          split_counter <= ctr_next;
          state         <= S_MUL_A;
        end

        S_MUL_A: begin
          if (mul_done) begin
            state <= S_MUL_B;
          end
        end

        S_MUL_B: begin
          if (mul_done) begin
            words[draw_idx] <= mul_prod ^ (mul_prod >> MIX_SH_C);
            draw_idx        <= draw_idx + 1'b1;
            if (draw_idx == 2'd3) begin
              // the power-up expansion gives no word
              init_q <= 1'b0;
              state  <= init_q ? S_IDLE : S_DONE;
            end else begin
              state <= S_DRAW;
            end
          end
        end

        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_raw    <= raw_q;
            rsp_ranged <= ranged_q;
            rsp_count  <= step_count;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/xss_checker.sv @@
// port-level checks for the xoshiro256** generator, bound to the top level
// depends on xss_pkg and xoshiro256ss_generator_macros.svh
`include "xoshiro256ss_generator_macros.svh"

module xss_port_checks (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [xss_pkg::WORD_W-1:0] rsp_raw_word
);
  import xss_pkg::*;

  // one word in flight: the request side closes after each accept
  `XSS_ASSERT_NXT(a_one_in_flight, req_valid && req_ready, !req_ready)

  // seed expansion after reset keeps requests out
  `XSS_ASSERT_NXT_RAW(a_init_busy, rst, !req_ready)

  // a new response only comes out of a busy cycle
  `XSS_ASSERT_IMP(a_rsp_from_busy, $rose(rsp_valid), !$past(req_ready))

  `XSS_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_raw_word))

endmodule

bind xoshiro256ss_generator xss_port_checks u_xss_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_raw_word (rsp.raw_word)
);

@@ bench/xss_checker.sv @@
// response checker for the xoshiro256** generator: tracks seed writes and requests,
// predicts each response and compares it field by field
// depends on xss_pkg and the channel interfaces in xss_ifs.sv
module xss_checker (
  input  logic clk,
  input  logic rst,
  xss_cfg_if   cfg,
  xss_req_if   req,
  xss_rsp_if   rsp,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import xss_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0]         raw_word;
    logic signed [RANGE_W-1:0] ranged_value;
    logic [WORD_W-1:0]         generated_count;
  } draw_t;

  logic [WORD_W-1:0] gen_w [4];
  logic [WORD_W-1:0] mix_ctr;
  logic [WORD_W-1:0] step_total;
  logic [WORD_W-1:0] seed_reg;
  draw_t             draws_due [$];
  int                miss_total = 0;

  function automatic logic [WORD_W-1:0] splitmix_next();
    logic [WORD_W-1:0] z;
    mix_ctr = mix_ctr + GOLDEN_INC;
    z = mix_ctr;
    z = (z ^ (z >> MIX_SH_A)) * MIX_MUL_A;
    z = (z ^ (z >> MIX_SH_B)) * MIX_MUL_B;
    return z ^ (z >> MIX_SH_C);
  endfunction

  function automatic void expand_seed(input logic [WORD_W-1:0] s);
    mix_ctr = s;
    for (int i = 0; i < 4; i++) gen_w[i] = splitmix_next();
  endfunction

  function automatic logic [WORD_W-1:0] advance_state();
    logic [WORD_W-1:0] m;
    logic [WORD_W-1:0] scrambled;
    logic [WORD_W-1:0] t;
    m = gen_w[1] * 64'd5;
    scrambled = {m[56:0], m[63:57]} * 64'd9;
    t = gen_w[1] << XS_SHIFT;
    gen_w[2] = gen_w[2] ^ gen_w[0];
    gen_w[3] = gen_w[3] ^ gen_w[1];
    gen_w[1] = gen_w[1] ^ gen_w[2];
    gen_w[0] = gen_w[0] ^ gen_w[3];
    gen_w[2] = gen_w[2] ^ t;
    gen_w[3] = {gen_w[3][18:0], gen_w[3][63:19]};
    step_total = step_total + 1;
    return scrambled;
  endfunction

  function automatic draw_t predict_draw(input op_t op, input logic signed [RANGE_W-1:0] lo,
                                         input logic signed [RANGE_W-1:0] hi);
    draw_t             d;
    logic [WORD_W-1:0] lo_x;
    logic [WORD_W-1:0] hi_x;
    logic [WORD_W-1:0] span;
    logic [WORD_W-1:0] total;
    d = '0;
    case (op)
      OP_RAW: begin
        d.raw_word = advance_state();
      end
      OP_RANGE: begin
        // empty or inverted range gives the low bound and leaves the state alone
        if (lo >= hi) begin
          d.ranged_value = lo;
        end else begin
          lo_x = {{32{lo[31]}}, lo};
          hi_x = {{32{hi[31]}}, hi};
          span = hi_x - lo_x + 64'd1;
          d.raw_word = advance_state();
          total = lo_x + (d.raw_word % span);
          d.ranged_value = total[RANGE_W-1:0];
        end
      end
      OP_RESEED: begin
        expand_seed(seed_reg);
      end
      OP_CLEAR: begin
        step_total = '0;
      end
      default: ;
    endcase
    d.generated_count = step_total;
    return d;
  endfunction

  task automatic report_miss(input string msg);
    miss_total++;
    if (miss_total <= 50) $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string field, input logic [WORD_W-1:0] got,
                             input logic [WORD_W-1:0] want);
    if (got !== want) report_miss($sformatf("%s is %h, predicted %h", field, got, want));
  endtask

  always @(posedge clk) begin
    draw_t want;
    if (rst) begin
      seed_reg = '0;
      step_total = '0;
      expand_seed('0);
      draws_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) seed_reg = cfg.seed_value;
      // response first: a word accepted this edge belongs to an earlier request
      if (rsp.valid && rsp.ready) begin
        if (draws_due.size() == 0) begin
          report_miss("response word with nothing outstanding");
        end else begin
          want = draws_due.pop_front();
          check_field("raw_word", rsp.raw_word, want.raw_word);
          check_field("ranged_value", {{(WORD_W-RANGE_W){1'b0}}, rsp.ranged_value},
                      {{(WORD_W-RANGE_W){1'b0}}, want.ranged_value});
          check_field("generated_count", rsp.generated_count, want.generated_count);
        end
      end
      if (req.valid && req.ready)
        draws_due.push_back(predict_draw(op_t'(req.opcode), req.range_low, req.range_high));
    end
    fail_count <= miss_total;
    pending <= draws_due.size();
  end

endmodule

@@ bench/tb_xoshiro256ss_generator.sv @@
// top of the xoshiro256** generator bench: clock, reset, request and seed stimulus,
// response back-pressure and the verdict
// depends on xss_pkg, xss_ifs.sv, the generator RTL and xss_checker
module tb_xoshiro256ss_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import xss_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic signed [RANGE_W-1:0] I32_MIN = 32'sh8000_0000;
  localparam logic signed [RANGE_W-1:0] I32_MAX = 32'sh7fff_ffff;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 300;

  logic        clk;
  logic        rst;
  int          fail_count;
  int          pending;
  int unsigned cycle_count = 0;
  int          burst_left = 0;

  xss_cfg_if cfg_ch ();
  xss_req_if req_ch ();
  xss_rsp_if rsp_ch ();

  xoshiro256ss_generator DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  xss_checker u_watch (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_word(input op_t op, input logic signed [RANGE_W-1:0] lo,
                           input logic signed [RANGE_W-1:0] hi);
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.range_low <= lo;
    req_ch.range_high <= hi;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    // bursts of back-to-back words, then a gap of random length
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_ch.valid <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(13, 90) : $urandom_range(1, 12))
        @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 10);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_seed(input logic [WORD_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.seed_value <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_word();
    logic signed [RANGE_W-1:0] lo;
    logic signed [RANGE_W-1:0] hi;
    int                        pick;
    op_t                       op;
    lo = $urandom;
    hi = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 42) op = OP_RAW;
    else if (pick < 88) op = OP_RANGE;
    else if (pick < 94) op = OP_RESEED;
    else op = OP_CLEAR;
    if (op == OP_RANGE) begin
      case ($urandom_range(0, 5))
        1: hi = lo + $urandom_range(1, 16);
        2: hi = lo;
        3: hi = lo - $urandom_range(1, 16);
        4: begin
          if ($urandom_range(0, 1) == 0) lo = I32_MIN;
          hi = I32_MAX;
        end
        5: hi = lo + (32'sd1 << $urandom_range(0, 31)) - 1;
        default: ;
      endcase
    end
    send_word(op, lo, hi);
  endtask

  // receiver: stretches of steady, patchy and sparse ready, with long hold-offs
  initial begin
    int seen;
    int mode;
    int stretch;
    int hold_at;
    seen = 0;
    stretch = 0;
    hold_at = 150;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) seen++;
      if (seen >= hold_at) begin
        hold_at += 900;
        rsp_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        if (stretch == 0) begin
          mode = $urandom_range(0, 2);
          stretch = $urandom_range(20, 200);
        end
        stretch--;
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= ($urandom_range(0, 9) < 7);
          default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    logic [WORD_W-1:0] seeds [PHASES];
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.opcode <= OP_RAW;
    req_ch.range_low <= '0;
    req_ch.range_high <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.seed_value <= '0;
    seeds[0] = '0;
    seeds[1] = '1;
    seeds[2] = {$urandom, $urandom};
    seeds[3] = 64'd1;
    seeds[4] = 64'h8000_0000_0000_0000;
    seeds[5] = {$urandom, $urandom};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // the block expands seed zero after reset before taking requests
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        repeat (4) @(posedge clk);
      end
      write_seed(seeds[p]);
      if (p == 0) begin
        send_word(OP_RAW, '0, '0);
        send_word(OP_RAW, I32_MAX, I32_MIN);
        send_word(OP_RANGE, 0, 1);
        send_word(OP_RANGE, I32_MIN, I32_MAX);
        send_word(OP_RANGE, 5, 5);
        send_word(OP_RANGE, 7, -3);
        send_word(OP_RANGE, I32_MAX, I32_MIN);
        send_word(OP_RANGE, I32_MIN, I32_MIN);
        send_word(OP_RANGE, I32_MAX, I32_MAX);
        send_word(OP_RANGE, I32_MIN, I32_MIN + 1);
        send_word(OP_RANGE, I32_MAX - 1, I32_MAX);
        send_word(OP_RANGE, -1, 0);
        send_word(OP_RANGE, -100, 100);
        send_word(OP_RANGE, 0, I32_MAX);
        send_word(OP_RANGE, I32_MIN, 0);
        send_word(OP_CLEAR, '1, '1);
        send_word(OP_RANGE, 3, 3);
        send_word(OP_RAW, '0, '0);
        send_word(OP_RESEED, '0, '0);
        send_word(OP_RAW, '0, '0);
        send_word(OP_RANGE, I32_MIN, I32_MAX);
        send_word(OP_CLEAR, '0, '0);
        send_word(OP_RESEED, I32_MIN, I32_MAX);
        send_word(OP_RANGE, -8, 7);
      end else begin
        // pick up the new seed straight away
        send_word(OP_RESEED, '0, '0);
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) random_word();
    end

    wait_drained();
    repeat (600) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/xss_pkg.sv
design/xss_ifs.sv
design/xss_mul.sv
design/xss_mod.sv
design/xoshiro256ss_generator.sv
design/xss_checker.sv
bench/xss_checker.sv
bench/tb_xoshiro256ss_generator.sv
